// ===== rtl/decimal_digit_splitter_defines.svh =====
// Assertion macros shared by the RTL of the decimal digit splitter.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef DECIMAL_DIGIT_SPLITTER_DEFINES_SVH
`define DECIMAL_DIGIT_SPLITTER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define DDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be true outside reset.
`define DDS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/ddsp_pkg.sv =====
package ddsp_pkg;

  localparam int DIGIT_W        = 4;
  localparam int INPUT_BITS_DEF = 32;
  localparam int IN_DATA_W      = 32;
  localparam int OUT_DATA_W     = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // Per-cycle command broadcast to every digit cell.
  typedef struct packed {
    logic clear;    // load zero
    logic convert;  // add-3 correction, then shift one bit in
    logic move;     // take the lower neighbor's digit
  } ctl_t;

endpackage

// ===== rtl/ddsp_cell.sv =====
module ddsp_cell (
  input  logic                        clk,
  input  ddsp_pkg::ctl_t              ctl,
  input  logic                        bit_in,
  input  logic [ddsp_pkg::DIGIT_W-1:0] digit_in,
  output logic                        carry_out,
  output logic [ddsp_pkg::DIGIT_W-1:0] digit
);
  import ddsp_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] corr;

  // A digit of five or more overflows past nine when doubled, so add three first.
  assign corr      = (digit_r >= DIGIT_W'(5)) ? digit_r + DIGIT_W'(3) : digit_r;
  assign carry_out = corr[DIGIT_W-1];
  assign digit     = digit_r;

  always_comb begin
    priority if (ctl.clear) begin
      digit_nxt = '0;
    end else if (ctl.convert) begin
      digit_nxt = {corr[DIGIT_W-2:0], bit_in};
    end else if (ctl.move) begin
      digit_nxt = digit_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// ===== rtl/decimal_digit_splitter.sv =====
// Channel  | Direction | tdata (low bit up)                  | tlast      | tuser
// in_      | slave     | code_value[31:0]                    | -          | -
// out_     | master    | digit, position, digit_count, zeros | last_digit | empty_code
//
// The conversion runs one input bit per cycle through the row of digit cells;
// the emit phase then shifts one digit per cycle out of the top cell while the
// result slot is free. Reset (rst_n, synchronous, active low) clears the control
// state only. A stalled result slot holds the emit phase without losing a digit,
// and the next code is taken while the last result still waits.
`include "decimal_digit_splitter_defines.svh"

module decimal_digit_splitter #(
  parameter int INPUT_BITS = ddsp_pkg::INPUT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ddsp_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] code_value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ddsp_pkg::OUT_DATA_W-1:0] out_tdata,  // [3:0] digit, [7:4] position,
                                                      // [11:8] digit_count, [15:12] zero
  output logic                            out_tlast,  // last_digit
  output logic                            out_tuser   // empty_code
);
  import ddsp_pkg::*;

  // Decimal digits of 2**INPUT_BITS - 1, i.e. ceil(INPUT_BITS * log10(2)).
  localparam int NUM_DIGITS = (INPUT_BITS * 30103 + 99999) / 100000;
  localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
  localparam int BIT_W      = (INPUT_BITS > 1) ? $clog2(INPUT_BITS) : 1;

  state_t state_r, state_nxt;
  ctl_t   ctl;

  logic [INPUT_BITS-1:0] sr_r;
  logic [BIT_W-1:0]      bit_cnt_r;
  logic [CNT_W-1:0]      rem_r;
  logic [DIGIT_W-1:0]    cnt_r;
  logic [DIGIT_W-1:0]    pos_r;
  logic                  empty_r;

  logic                  out_tvalid_r;
  logic [DIGIT_W-1:0]    out_digit_r;
  logic [DIGIT_W-1:0]    out_pos_r;
  logic [DIGIT_W-1:0]    out_cnt_r;
  logic                  out_last_r;
  logic                  out_empty_r;

  logic [DIGIT_W-1:0]    dig   [NUM_DIGITS];
  logic                  carry [NUM_DIGITS];

  logic                  in_acc;
  logic                  slot_free;
  logic                  load;
  logic                  last_now;
  logic [DIGIT_W-1:0]    top_digit;

  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;
  assign top_digit = dig[NUM_DIGITS-1];
  assign last_now  = empty_r || (pos_r + DIGIT_W'(1) == cnt_r);
  assign load      = (state_r == ST_EMIT) && slot_free;

  // Row of BCD cells: cell 0 holds the least significant digit. During conversion
  // each cell passes its overflow bit up; during emit each takes the digit below.
  for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
    logic               bit_in;
    logic [DIGIT_W-1:0] digit_in;
    if (k == 0) begin : g_first
      assign bit_in   = sr_r[INPUT_BITS-1];
      assign digit_in = '0;
    end else begin : g_rest
      assign bit_in   = carry[k-1];
      assign digit_in = dig[k-1];
    end
    ddsp_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .bit_in    (bit_in),
      .digit_in  (digit_in),
      .carry_out (carry[k]),
      .digit     (dig[k])
    );
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt_r == '0) state_nxt = ST_SKIP;
      end
      ST_SKIP: begin
        // Leave once the top cell holds a significant digit or none are left.
        if (rem_r == '0 || top_digit != '0) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (load && last_now) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Cell commands.
  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_IDLE: ctl.clear   = in_acc;
      ST_CONV: ctl.convert = 1'b1;
      ST_SKIP: ctl.move    = (rem_r != '0) && (top_digit == '0);
      ST_EMIT: ctl.move    = load;
      default: ctl         = '0;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sr_r      <= in_tdata[INPUT_BITS-1:0];
      bit_cnt_r <= BIT_W'(INPUT_BITS - 1);
      rem_r     <= CNT_W'(NUM_DIGITS);
      pos_r     <= '0;
    end
    if (state_r == ST_CONV) begin
      sr_r      <= sr_r << 1;
      bit_cnt_r <= bit_cnt_r - BIT_W'(1);
    end
    if (ctl.move && state_r == ST_SKIP) begin
      rem_r <= rem_r - CNT_W'(1);
    end
    if (state_r == ST_SKIP && state_nxt == ST_EMIT) begin
      cnt_r   <= DIGIT_W'(rem_r);
      empty_r <= (rem_r == '0);
    end
    if (load) begin
      out_digit_r <= empty_r ? '0 : top_digit;
      out_pos_r   <= pos_r;
      out_cnt_r   <= cnt_r;
      out_last_r  <= last_now;
      out_empty_r <= empty_r;
      pos_r       <= pos_r + DIGIT_W'(1);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W - 3 * DIGIT_W){1'b0}}, out_cnt_r, out_pos_r, out_digit_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_empty_r;

  `DDS_ASSERT(a_accept_starts_conv, in_tvalid && in_tready |=> state_r == ST_CONV, "accepted code did not start conversion")
  `DDS_ASSERT(a_empty_is_last, out_tvalid && out_tuser |-> out_tlast, "empty result not marked last")
  `DDS_NEVER(a_digit_range, out_tvalid && (out_tdata[3:0] > 4'd9), "digit out of decimal range")
  `DDS_NEVER(a_pos_below_count, out_tvalid && !out_tuser && (out_tdata[7:4] >= out_tdata[11:8]), "position not below digit count")

endmodule

// ===== bench/digit_stream_checker.sv =====
module digit_stream_checker #(
  parameter int INPUT_BITS = ddsp_pkg::INPUT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [ddsp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ddsp_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tlast,
  input  logic                            out_tuser,
  output int                              mismatch_count,
  output int                              digits_pending
);

  localparam logic [31:0] CODE_MASK = (INPUT_BITS >= 32) ? 32'hFFFF_FFFF :
                                      ((32'd1 << INPUT_BITS) - 32'd1);
  localparam int MAX_DIGITS = 10;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [3:0] digit;
    logic [3:0] position;
    logic [3:0] digit_count;
    logic       last_digit;
    logic       empty_code;
  } digit_result_t;

  digit_result_t expected_digits[$];

  initial begin
    mismatch_count = 0;
    digits_pending = 0;
  end

  // Splits one code into its decimal digits, most significant first.
  function automatic void queue_expected_digits(input logic [31:0] raw_code);
    logic [31:0]   rest;
    logic [3:0]    lsd_first [MAX_DIGITS];
    int            num_digits;
    digit_result_t res;
    rest = raw_code & CODE_MASK;
    num_digits = 0;
    while (rest != 32'd0) begin
      lsd_first[num_digits] = 4'(rest % 32'd10);
      rest = rest / 32'd10;
      num_digits++;
    end
    if (num_digits == 0) begin
      res.digit       = 4'd0;
      res.position    = 4'd0;
      res.digit_count = 4'd0;
      res.last_digit  = 1'b1;
      res.empty_code  = 1'b1;
      expected_digits.push_back(res);
    end else begin
      for (int i = 0; i < num_digits; i++) begin
        res.digit       = lsd_first[num_digits - 1 - i];
        res.position    = 4'(i);
        res.digit_count = 4'(num_digits);
        res.last_digit  = (i == num_digits - 1);
        res.empty_code  = 1'b0;
        expected_digits.push_back(res);
      end
    end
  endfunction

  always @(posedge clk) begin : watch_channels
    digit_result_t want;
    digit_result_t got;
    logic [3:0]    got_pad;
    if (rst_n) begin
      // Results are retired before a code accepted on the same edge is added.
      if (out_tvalid && out_tready) begin
        got.digit       = out_tdata[3:0];
        got.position    = out_tdata[7:4];
        got.digit_count = out_tdata[11:8];
        got.last_digit  = out_tlast;
        got.empty_code  = out_tuser;
        got_pad         = out_tdata[15:12];
        if (expected_digits.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected result digit=%0d pos=%0d count=%0d last=%0b empty=%0b",
                     $time, got.digit, got.position, got.digit_count,
                     got.last_digit, got.empty_code);
        end else begin
          want = expected_digits.pop_front();
          if (got !== want || got_pad !== 4'd0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("%0t: mismatch expected digit=%0d pos=%0d count=%0d last=%0b empty=%0b pad=0",
                       $time, want.digit, want.position, want.digit_count,
                       want.last_digit, want.empty_code);
              $display("%0t:               got digit=%0d pos=%0d count=%0d last=%0b empty=%0b pad=%0d",
                       $time, got.digit, got.position, got.digit_count,
                       got.last_digit, got.empty_code, got_pad);
            end
          end
        end
      end
      if (in_tvalid && in_tready)
        queue_expected_digits(in_tdata);
      digits_pending = expected_digits.size();
    end
  end

endmodule

// ===== bench/tb_decimal_digit_splitter.sv =====
// Stimulus and verdict for the decimal digit splitter. The checker instance
// watches both channels, predicts every digit transaction and counts mismatches;
// this module only produces code transactions, throttles the result channel and
// decides pass or fail at the end.
module tb_decimal_digit_splitter;

  // The result-channel hold-off is long enough to back the block up into its
  // input channel.
  localparam int LONG_HOLD_CYCLES = 400;
  // Cycles allowed after the last expected digit before the verdict, so that
  // any stray transaction the block might still produce gets seen.
  localparam int DRAIN_CYCLES     = 80;
  localparam int CYCLE_LIMIT      = 300000;
  localparam int RANDOM_CODES     = 137;
  localparam int QUIET_TAIL       = 30;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [ddsp_pkg::IN_DATA_W-1:0]  in_tdata;    // [31:0] code_value
  logic                            out_tvalid;
  logic                            out_tready;
  logic [ddsp_pkg::OUT_DATA_W-1:0] out_tdata;   // [3:0] digit, [7:4] position,
                                                // [11:8] digit_count, [15:12] zero
  logic                            out_tlast;   // last_digit
  logic                            out_tuser;   // empty_code

  int mismatch_count;
  int digits_pending;
  int cycle_count;

  // Shared between the stimulus process and the result-channel process.
  bit idle_on;
  bit long_hold_pending;

  decimal_digit_splitter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  digit_stream_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .digits_pending (digits_pending)
  );

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The cycle counter is the only guard against a hung block.
  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one code and returns at the edge where the transaction is accepted.
  // When no idle burst is drawn, tvalid simply stays high and only the data
  // changes, so tvalid never gets two assignments in one time step.
  task automatic send_code(input logic [31:0] code);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    do @(posedge clk); while (!in_tready);
  endtask

  // Draws a random code. Most draws pick a digit count first and then a value
  // with exactly that many digits, so short and long runs are equally common;
  // the rest are zero, full-range values and values close to the top.
  function automatic logic [31:0] random_code();
    longint unsigned low_bound;
    longint unsigned high_bound;
    int              num_digits;
    logic [31:0]     code;
    case ($urandom_range(0, 9))
      0: code = 32'd0;
      1: code = 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
      2, 3: code = $urandom();
      default: begin
        num_digits = $urandom_range(1, 10);
        low_bound  = 1;
        repeat (num_digits - 1) low_bound = low_bound * 10;
        high_bound = low_bound * 10 - 1;
        if (high_bound > 64'hFFFF_FFFF) high_bound = 64'hFFFF_FFFF;
        code = $urandom_range(32'(high_bound), 32'(low_bound));
      end
    endcase
    return code;
  endfunction

  // Result-channel throttling. Each pass of the loop makes exactly one
  // assignment to out_tready at one edge. A requested long hold-off is counted
  // here, while the stimulus process keeps offering codes.
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 8);
        out_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_tvalid         = 1'b0;
    in_tdata          = '0;
    idle_on           = 1'b1;
    long_hold_pending = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed codes: zero (also twice in a row), single digits, the power of ten
    // boundaries 10, 100, 10**6 and 10**9 that change the digit count, the largest
    // ten-digit values, alternating bit patterns, and codes with inner zero digits.
    send_code(32'd0);
    send_code(32'd0);
    send_code(32'd1);
    send_code(32'd9);
    send_code(32'd10);
    send_code(32'd90);
    send_code(32'd99);
    send_code(32'd100);
    send_code(32'd12345);
    send_code(32'd999999);
    send_code(32'd1000000);
    send_code(32'd909090909);
    send_code(32'd999999999);
    send_code(32'd1000000000);
    send_code(32'd1000000001);
    send_code(32'd1234567890);
    send_code(32'h8000_0000);
    send_code(32'hAAAA_AAAA);
    send_code(32'h5555_5555);
    send_code(32'd4000000000);
    send_code(32'hFFFF_FFFE);
    send_code(32'hFFFF_FFFF);
    send_code(32'd0);

    // Random codes. Partway through, the result channel is held off for a
    // long stretch so the block fills up and stalls its input; the final
    // stretch runs with no idling on either side.
    for (int n = 0; n < RANDOM_CODES; n++) begin
      if (n == 60) long_hold_pending = 1'b1;
      if (n == RANDOM_CODES - QUIET_TAIL) idle_on = 1'b0;
      send_code(random_code());
    end
    in_tvalid <= 1'b0;

    // One more edge makes sure the checker has taken in the final code
    // before the pending count is trusted.
    @(posedge clk);
    while (digits_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && digits_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ddsp_pkg.sv
rtl/ddsp_cell.sv
rtl/decimal_digit_splitter.sv
bench/digit_stream_checker.sv
bench/tb_decimal_digit_splitter.sv
